FILE: src/nms_pkg.sv
// ----------------------------------------------------------------------------
// nms_pkg: shared definitions for the non-maximum suppression block
// Field widths, configuration register indexes, direction codes, the angle
// quantizer and the stage control bundle.
// ----------------------------------------------------------------------------
package nms_pkg;

    localparam int NMS_MAX_WIDTH = 1024;
    localparam int NMS_MAG_BITS  = 8;

    localparam int COORD_BITS  = 10;
    localparam int ANGLE_BITS  = 10;
    localparam int DIM_BITS    = 11;
    localparam int DIM_CAP     = 1024;
    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_SLOTS = 3;

    localparam logic [DIM_BITS-1:0] DIM_MIN_V    = 11'd3;
    localparam logic [DIM_BITS-1:0] DIM_CAP_V    = 11'd1024;
    localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 11'd480;

    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    // Sector bounds in half degrees: 22.5, 67.5, 112.5 and 157.5 degrees.
    localparam logic signed [ANGLE_BITS-1:0] ANG_22  = 10'sd45;
    localparam logic signed [ANGLE_BITS-1:0] ANG_67  = 10'sd135;
    localparam logic signed [ANGLE_BITS-1:0] ANG_112 = 10'sd225;
    localparam logic signed [ANGLE_BITS-1:0] ANG_157 = 10'sd315;

    typedef logic [1:0] nms_dir_t;
    localparam nms_dir_t DIR_HORIZ     = 2'd0;
    localparam nms_dir_t DIR_DIAG_UP   = 2'd1;
    localparam nms_dir_t DIR_VERT      = 2'd2;
    localparam nms_dir_t DIR_DIAG_DOWN = 2'd3;

    // Control bundle of the pixel that sits in the window stage.
    typedef struct packed {
        logic                  valid;
        logic                  emit_main;
        logic                  emit_col;
        logic                  emit_row;
        logic                  interior;
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] col;
    } nms_stage_t;

    function automatic nms_dir_t quantize_angle(input logic signed [ANGLE_BITS-1:0] a);
        nms_dir_t d;
        if ((a > -ANG_22 && a <= ANG_22) || a > ANG_157 || a <= -ANG_157) begin
            d = DIR_HORIZ;
        end else if ((a > ANG_22 && a <= ANG_67) || (a > -ANG_157 && a <= -ANG_112)) begin
            d = DIR_DIAG_UP;
        end else if ((a > ANG_67 && a <= ANG_112) || (a > -ANG_112 && a <= -ANG_67)) begin
            d = DIR_VERT;
        end else begin
            d = DIR_DIAG_DOWN;
        end
        return d;
    endfunction

    function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
                                                      input logic [DIM_BITS-1:0] hi);
        logic [DIM_BITS-1:0] r;
        if (v < DIM_MIN_V) begin
            r = DIM_MIN_V;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

FILE: src/nms_channels.sv
// ----------------------------------------------------------------------------
// nms_channels: valid/ready channels of the suppression block
// One interface for incoming pixels and one for outgoing results.
// ----------------------------------------------------------------------------
interface nms_pixel_if import nms_pkg::*; #(
    parameter int MAG_BITS = NMS_MAG_BITS
) ();
    logic                         valid;
    logic                         ready;
    logic [MAG_BITS-1:0]          magnitude;
    logic signed [ANGLE_BITS-1:0] angle;

    modport source (output valid, output magnitude, output angle, input ready);
    modport sink   (input valid, input magnitude, input angle, output ready);
endinterface

interface nms_result_if import nms_pkg::*; #(
    parameter int MAG_BITS = NMS_MAG_BITS
) ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] out_row;
    logic [COORD_BITS-1:0] out_col;
    logic [MAG_BITS-1:0]   value;
    logic                  last_of_run;

    modport source (output valid, output out_row, output out_col, output value,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_row, input out_col, input value,
                    input last_of_run, output ready);
endinterface

FILE: src/canny_non_max_suppression.sv
// ----------------------------------------------------------------------------
// canny_non_max_suppression: non-maximum suppression on a pixel stream
// Raster pixels with gradient magnitude and angle go in; each pixel comes
// out once, with its coordinates, suppressed to 0 if interior and no ridge.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake     Payload
//  --------  ---  ------------  -------------------------------------------
//  pixel     in   valid/ready   magnitude, angle (half degrees, signed)
//  result    out  valid/ready   out_row, out_col, value, last_of_run
//  cfg       in   cfg_we        cfg_index, cfg_data (write only)
//
// One pixel item is accepted per cycle while pixel ready is high. Its
// results enter the result queue in the cycle after acceptance; the line
// buffer read happens on the accept edge and the read-modify-write of that
// column completes in the following cycle. The output port delivers one
// result item per cycle while result ready is high. On the last column a
// pixel below row 0 yields two items, but the first pixel of the next row
// yields none, so the stream keeps its rate. On the last row each pixel
// yields one to three items, the queue fills and the input is held off
// until it drains. Reset clears the counters, the window and the queue at
// once; the line buffers are not cleared and hold meaningful data only
// once written.
//
module canny_non_max_suppression import nms_pkg::*; #(
    parameter int MAX_WIDTH = NMS_MAX_WIDTH,
    parameter int MAG_BITS  = NMS_MAG_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    nms_pixel_if.sink                 pixel,
    nms_result_if.source              result,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [DIM_BITS-1:0]       cfg_data
);

    localparam int ADDR_BITS = $clog2(MAX_WIDTH);
    localparam int WIDTH_CAP = (MAX_WIDTH < DIM_CAP) ? MAX_WIDTH : DIM_CAP;
    localparam logic [DIM_BITS-1:0] WIDTH_CAP_V = DIM_BITS'(WIDTH_CAP);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_BITS:0] READY_LIMIT = (CNT_BITS + 1)'(QUEUE_DEPTH - QUEUE_SLOTS);

    // Configuration registers.
    logic [DIM_BITS-1:0] width_reg;
    logic [DIM_BITS-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
            endcase
        end
    end

    // Effective dimensions: out-of-range settings are clamped.
    logic [DIM_BITS-1:0] w_eff;
    logic [DIM_BITS-1:0] h_eff;
    assign w_eff = clamp_dim(width_reg, WIDTH_CAP_V);
    assign h_eff = clamp_dim(height_reg, DIM_CAP_V);

    // Position of the next incoming pixel.
    logic [COORD_BITS-1:0] row_reg, row_next;
    logic [COORD_BITS-1:0] col_reg, col_next;
    logic [DIM_BITS-1:0]   row_ext;
    logic [DIM_BITS-1:0]   col_ext;
    logic                  last_col;
    logic                  last_row;
    logic                  accept;

    assign row_ext  = {1'b0, row_reg};
    assign col_ext  = {1'b0, col_reg};
    // A counter past the last column or row (after a size change) wraps too.
    assign last_col = col_ext >= w_eff - DIM_BITS'(1);
    assign last_row = row_ext >= h_eff - DIM_BITS'(1);

    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        if (accept) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + COORD_BITS'(1);
            end else begin
                col_next = col_reg + COORD_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            row_reg <= '0;
            col_reg <= '0;
        end else begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // Window stage: the pixel accepted on the previous edge. The pixel at
    // (r, c) completes the window centered on (r-1, c-1).
    nms_stage_t                   stage_reg, stage_next;
    logic [MAG_BITS-1:0]          mag_s1_reg;
    logic signed [ANGLE_BITS-1:0] ang_s1_reg;
    logic [ADDR_BITS-1:0]         addr_s1_reg;
    logic [ADDR_BITS-1:0]         rd_addr;

    // The column count never reaches MAX_WIDTH, so it is the address itself.
    assign rd_addr = ADDR_BITS'(col_reg);

    always_comb begin
        stage_next           = '0;
        stage_next.valid     = accept;
        stage_next.emit_main = (row_reg != '0) && (col_reg != '0);
        stage_next.emit_col  = stage_next.emit_main && last_col;
        stage_next.emit_row  = last_row;
        stage_next.interior  = (row_reg >= COORD_BITS'(2)) && (row_ext <= h_eff - DIM_BITS'(1))
                            && (col_reg >= COORD_BITS'(2)) && (col_ext <= w_eff - DIM_BITS'(1));
        stage_next.row       = row_reg;
        stage_next.col       = col_reg;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            stage_reg <= '0;
        end else begin
            stage_reg <= stage_next;
        end
    end

    always_ff @(posedge clk) begin
        if (accept) begin
            mag_s1_reg  <= pixel.magnitude;
            ang_s1_reg  <= pixel.angle;
            addr_s1_reg <= rd_addr;
        end
    end

    // Line buffers and window. Consecutive pixels always touch different
    // columns and a column comes back no sooner than three pixels later,
    // after its write-back, so the read-modify-write needs no bypass.
    logic [MAG_BITS-1:0] value_main;
    logic [MAG_BITS-1:0] value_col;

    nms_line_window #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAG_BITS  (MAG_BITS),
        .ADDR_BITS (ADDR_BITS)
    ) u_line_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (accept),
        .rd_addr    (rd_addr),
        .stage      (stage_reg),
        .wr_addr    (addr_s1_reg),
        .mag        (mag_s1_reg),
        .ang        (ang_s1_reg),
        .value_main (value_main),
        .value_col  (value_col)
    );

    // Up to three results per pixel, in this order: the window center,
    // the pixel above on the last column, and the pixel itself on the last row.
    logic [QUEUE_SLOTS-1:0] push;
    logic [COORD_BITS-1:0]  push_row   [QUEUE_SLOTS];
    logic [COORD_BITS-1:0]  push_col   [QUEUE_SLOTS];
    logic [MAG_BITS-1:0]    push_value [QUEUE_SLOTS];

    assign push[0]       = stage_reg.valid && stage_reg.emit_main;
    assign push[1]       = stage_reg.valid && stage_reg.emit_col;
    assign push[2]       = stage_reg.valid && stage_reg.emit_row;
    assign push_row[0]   = stage_reg.row - COORD_BITS'(1);
    assign push_col[0]   = stage_reg.col - COORD_BITS'(1);
    assign push_value[0] = value_main;
    assign push_row[1]   = stage_reg.row - COORD_BITS'(1);
    assign push_col[1]   = stage_reg.col;
    assign push_value[1] = value_col;
    assign push_row[2]   = stage_reg.row;
    assign push_col[2]   = stage_reg.col;
    assign push_value[2] = mag_s1_reg;

    logic [CNT_BITS-1:0] q_count;
    logic [1:0]          s1_results;

    nms_out_queue #(
        .MAG_BITS (MAG_BITS)
    ) u_out_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_row   (push_row),
        .push_col   (push_col),
        .push_value (push_value),
        .out_valid  (result.valid),
        .out_ready  (result.ready),
        .out_row    (result.out_row),
        .out_col    (result.out_col),
        .out_value  (result.value),
        .out_last   (result.last_of_run),
        .count      (q_count)
    );

    // A new pixel is taken only if the queue can hold the results still in
    // the window stage plus a full run of three for the new one.
    assign s1_results  = {1'b0, push[0]} + {1'b0, push[1]} + {1'b0, push[2]};
    assign pixel.ready = ({1'b0, q_count} + (CNT_BITS + 1)'(s1_results)) <= READY_LIMIT;
    assign accept      = pixel.valid && pixel.ready;

endmodule

FILE: src/nms_line_window.sv
// ----------------------------------------------------------------------------
// nms_line_window: line buffer memory, 3x3 window and suppression test
// Each entry holds the angle and the two previous magnitudes of a column; it
// is read when the pixel enters and written back in the following cycle.
// ----------------------------------------------------------------------------
module nms_line_window import nms_pkg::*; #(
    parameter int MAX_WIDTH = NMS_MAX_WIDTH,
    parameter int MAG_BITS  = NMS_MAG_BITS,
    parameter int ADDR_BITS = $clog2(NMS_MAX_WIDTH)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [ADDR_BITS-1:0]         rd_addr,
    input  nms_stage_t                   stage,
    input  logic [ADDR_BITS-1:0]         wr_addr,
    input  logic [MAG_BITS-1:0]          mag,
    input  logic signed [ANGLE_BITS-1:0] ang,
    output logic [MAG_BITS-1:0]          value_main,
    output logic [MAG_BITS-1:0]          value_col
);

    localparam int ENTRY_BITS = ANGLE_BITS + 2 * MAG_BITS;

    logic [ENTRY_BITS-1:0]        line_mem [MAX_WIDTH];
    logic [ENTRY_BITS-1:0]        rd_data_reg;
    logic [MAG_BITS-1:0]          win_reg [9];
    logic [MAG_BITS-1:0]          win_next [9];
    logic signed [ANGLE_BITS-1:0] angle_hold_reg;

    logic signed [ANGLE_BITS-1:0] rd_ang;
    logic [MAG_BITS-1:0]          rd_prev;
    logic [MAG_BITS-1:0]          rd_prev2;
    logic [MAG_BITS-1:0]          ctr;
    logic [MAG_BITS-1:0]          n1;
    logic [MAG_BITS-1:0]          n2;
    nms_dir_t                     dir;

    assign rd_ang   = rd_data_reg[ENTRY_BITS-1 -: ANGLE_BITS];
    assign rd_prev  = rd_data_reg[2*MAG_BITS-1 -: MAG_BITS];
    assign rd_prev2 = rd_data_reg[MAG_BITS-1:0];

    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data_reg <= line_mem[rd_addr];
        end
        if (stage.valid) begin
            line_mem[wr_addr] <= {ang, mag, rd_prev};
        end
    end

    // Row 0 of the window is the oldest line, column 2 the newest pixel.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            win_next[i*3]   = win_reg[i*3+1];
            win_next[i*3+1] = win_reg[i*3+2];
        end
        win_next[2] = rd_prev2;
        win_next[5] = rd_prev;
        win_next[8] = mag;
    end

    assign dir = quantize_angle(angle_hold_reg);
    assign ctr = win_next[4];

    always_comb begin
        unique case (dir)
            DIR_HORIZ: begin
                n1 = win_next[5];
                n2 = win_next[3];
            end
            DIR_DIAG_UP: begin
                n1 = win_next[6];
                n2 = win_next[2];
            end
            DIR_VERT: begin
                n1 = win_next[7];
                n2 = win_next[1];
            end
            default: begin
                n1 = win_next[0];
                n2 = win_next[8];
            end
        endcase
    end

    always_comb begin
        if (stage.interior) begin
            value_main = (ctr > n1 && ctr > n2) ? ctr : '0;
        end else begin
            value_main = ctr;
        end
    end

    assign value_col = win_next[5];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= '0;
            end
            angle_hold_reg <= '0;
        end else if (stage.valid) begin
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= win_next[i];
            end
            angle_hold_reg <= rd_ang;
        end
    end

endmodule

FILE: src/nms_out_queue.sv
// ----------------------------------------------------------------------------
// nms_out_queue: result queue
// Takes up to three results per cycle in order and hands out one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module nms_out_queue import nms_pkg::*; #(
    parameter int MAG_BITS = NMS_MAG_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [QUEUE_SLOTS-1:0]      push,
    input  logic [COORD_BITS-1:0]       push_row   [QUEUE_SLOTS],
    input  logic [COORD_BITS-1:0]       push_col   [QUEUE_SLOTS],
    input  logic [MAG_BITS-1:0]         push_value [QUEUE_SLOTS],
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [COORD_BITS-1:0]       out_row,
    output logic [COORD_BITS-1:0]       out_col,
    output logic [MAG_BITS-1:0]         out_value,
    output logic                        out_last,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] count
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    logic [COORD_BITS-1:0] row_q   [QUEUE_DEPTH];
    logic [COORD_BITS-1:0] col_q   [QUEUE_DEPTH];
    logic [MAG_BITS-1:0]   value_q [QUEUE_DEPTH];
    logic                  last_q  [QUEUE_DEPTH];

    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic [PTR_BITS-1:0] slot_addr [QUEUE_SLOTS];
    logic                slot_last [QUEUE_SLOTS];
    logic [1:0]          n_push;
    logic                pop;

    // Results are packed in order; the final pushed one closes the run.
    assign slot_addr[0] = wr_ptr_reg;
    assign slot_addr[1] = wr_ptr_reg + PTR_BITS'(push[0]);
    assign slot_addr[2] = wr_ptr_reg + PTR_BITS'(push[0]) + PTR_BITS'(push[1]);
    assign slot_last[0] = !push[1] && !push[2];
    assign slot_last[1] = !push[2];
    assign slot_last[2] = 1'b1;

    assign n_push = {1'b0, push[0]} + {1'b0, push[1]} + {1'b0, push[2]};
    assign pop    = out_valid && out_ready;

    assign wr_ptr_next = wr_ptr_reg + PTR_BITS'(n_push);
    assign rd_ptr_next = rd_ptr_reg + PTR_BITS'(pop);
    assign count_next  = count_reg + CNT_BITS'(n_push) - CNT_BITS'(pop);

    always_ff @(posedge clk) begin
        for (int i = 0; i < QUEUE_SLOTS; i++) begin
            if (push[i]) begin
                row_q[slot_addr[i]]   <= push_row[i];
                col_q[slot_addr[i]]   <= push_col[i];
                value_q[slot_addr[i]] <= push_value[i];
                last_q[slot_addr[i]]  <= slot_last[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_row   = row_q[rd_ptr_reg];
    assign out_col   = col_q[rd_ptr_reg];
    assign out_value = value_q[rd_ptr_reg];
    assign out_last  = last_q[rd_ptr_reg];
    assign count     = count_reg;

endmodule

FILE: src/nms_checker.sv
// ----------------------------------------------------------------------------
// nms_checker: port-level checks for the suppression block
// Watches the pixel and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module nms_checker import nms_pkg::*; #(
    parameter int MAG_BITS = NMS_MAG_BITS
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  res_valid,
    input logic                  res_ready,
    input logic [COORD_BITS-1:0] res_row,
    input logic [COORD_BITS-1:0] res_col,
    input logic [MAG_BITS-1:0]   res_value,
    input logic                  res_last
);

    // A stalled result stays offered.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload.
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable({res_row, res_col, res_value, res_last}))
        else $error("result payload changed while stalled");

    // An empty queue refills only from an earlier accepted pixel, whose results pass the window stage register.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result appeared without a matching pixel");

    // The input is held off only while results are waiting.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> res_valid)
        else $error("input stalled with no result pending");

endmodule

bind canny_non_max_suppression nms_checker #(
    .MAG_BITS (MAG_BITS)
) u_nms_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pixel.valid),
    .in_ready  (pixel.ready),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_row   (result.out_row),
    .res_col   (result.out_col),
    .res_value (result.value),
    .res_last  (result.last_of_run)
);

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking regression for canny_non_max_suppression
// Streams raster pixel items through the block, predicts every result item
// with an independent model of the line buffers and the 3x3 window, and
// compares the results field by field in arrival order. Covers the reset
// geometry, clamped register values, sector boundaries, geometry changes
// in the middle of a frame and random frames with random idling.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import nms_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 5;
    localparam int STALL_PERCENT  = 18;
    // Results reach the output queue in the cycle after the pixel is taken,
    // so SETTLE_CYCLES spare cycles cover a pixel that produces nothing.
    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PIXELS  = 150;
    localparam int MAG_MAX        = (1 << NMS_MAG_BITS) - 1;
    localparam int WIDTH_CAP      = (NMS_MAX_WIDTH < DIM_CAP) ? NMS_MAX_WIDTH : DIM_CAP;

    // Sector edges in half degrees, taken from the package constants.
    localparam int EDGE_22  = ANG_22;
    localparam int EDGE_67  = ANG_67;
    localparam int EDGE_112 = ANG_112;
    localparam int EDGE_157 = ANG_157;

    typedef logic [NMS_MAG_BITS-1:0]      mag_t;
    typedef logic signed [ANGLE_BITS-1:0] angle_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] col;
        mag_t                  value;
        logic                  last;
    } pixel_result_t;

    // Content of generated frames: full random noise, tiny magnitudes that
    // force ties, or a bright column and row over a dim background.
    typedef enum int {FILL_NOISE, FILL_TIES, FILL_RIDGE} fill_style_t;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_IMAGE_WIDTH;
    logic [DIM_BITS-1:0]       cfg_data  = '0;

    nms_pixel_if  pixel_ch ();
    nms_result_if result_ch ();

    canny_non_max_suppression u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pixel_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow copy of the block state. Line buffer entries that were never
    // written read as zero here; the stimulus only lets such entries reach
    // window cells that no result depends on.
    // ------------------------------------------------------------------
    mag_t   row_above_mag [NMS_MAX_WIDTH] = '{default: '0};
    mag_t   row_above2_mag[NMS_MAX_WIDTH] = '{default: '0};
    angle_t row_above_ang [NMS_MAX_WIDTH] = '{default: '0};
    mag_t   window [9] = '{default: '0};
    angle_t center_angle = '0;
    int     next_row = 0;
    int     next_col = 0;

    logic [DIM_BITS-1:0] width_setting  = WIDTH_RESET;
    logic [DIM_BITS-1:0] height_setting = HEIGHT_RESET;

    pixel_result_t expected_pixels[$];

    int pixels_sent  = 0;
    int mismatches   = 0;
    int quiet_cycles = 0;
    int ridge_col    = 0;
    int ridge_row    = 0;
    bit pixel_gaps    = 1'b1;
    bit result_stalls = 1'b1;

    // A register below the legal range acts as 3, above it as the cap.
    function automatic int effective_dim(logic [DIM_BITS-1:0] setting, int hi);
        int v;
        v = int'(setting);
        if (v < int'(DIM_MIN_V)) begin
            v = int'(DIM_MIN_V);
        end else if (v > hi) begin
            v = hi;
        end
        return v;
    endfunction

    // Keeps the window center only if it is strictly above both neighbors
    // along the gradient direction that the angle falls into.
    function automatic mag_t ridge_or_zero(angle_t a);
        int       deg;
        nms_dir_t dir;
        mag_t     side_a;
        mag_t     side_b;
        deg = int'(a);
        if ((deg > -EDGE_22 && deg <= EDGE_22) || deg > EDGE_157 || deg <= -EDGE_157) begin
            dir = DIR_HORIZ;
        end else if ((deg > EDGE_22 && deg <= EDGE_67) ||
                     (deg > -EDGE_157 && deg <= -EDGE_112)) begin
            dir = DIR_DIAG_UP;
        end else if ((deg > EDGE_67 && deg <= EDGE_112) ||
                     (deg > -EDGE_112 && deg <= -EDGE_67)) begin
            dir = DIR_VERT;
        end else begin
            dir = DIR_DIAG_DOWN;
        end
        case (dir)
            DIR_HORIZ:   begin side_a = window[5]; side_b = window[3]; end
            DIR_DIAG_UP: begin side_a = window[6]; side_b = window[2]; end
            DIR_VERT:    begin side_a = window[7]; side_b = window[1]; end
            default:     begin side_a = window[0]; side_b = window[8]; end
        endcase
        return (window[4] > side_a && window[4] > side_b) ? window[4] : '0;
    endfunction

    function automatic pixel_result_t make_result(int row, int col, mag_t value);
        pixel_result_t res;
        res.row   = row[COORD_BITS-1:0];
        res.col   = col[COORD_BITS-1:0];
        res.value = value;
        res.last  = 1'b0;
        return res;
    endfunction

    // Advances the shadow state by one accepted pixel and queues the
    // results it causes, in the order the block must deliver them.
    function automatic void model_pixel(mag_t mag, angle_t ang);
        pixel_result_t found[3];
        int            count;
        int            w;
        int            h;
        int            r;
        int            c;
        bit            last_col;
        bit            last_row;
        bit            interior;
        angle_t        ang_ctr;
        w        = effective_dim(width_setting, WIDTH_CAP);
        h        = effective_dim(height_setting, DIM_CAP);
        r        = next_row;
        c        = next_col;
        last_col = c >= w - 1;
        last_row = r >= h - 1;
        ang_ctr  = center_angle;
        count    = 0;

        for (int i = 0; i < 3; i++) begin
            window[i * 3]     = window[i * 3 + 1];
            window[i * 3 + 1] = window[i * 3 + 2];
        end
        window[2] = row_above2_mag[c];
        window[5] = row_above_mag[c];
        window[8] = mag;

        if (r >= 1 && c >= 1) begin
            interior = r >= 2 && r <= h - 1 && c >= 2 && c <= w - 1;
            found[count] = make_result(r - 1, c - 1,
                                       interior ? ridge_or_zero(ang_ctr) : window[4]);
            count++;
            if (last_col) begin
                found[count] = make_result(r - 1, c, window[5]);
                count++;
            end
        end
        if (last_row) begin
            found[count] = make_result(r, c, mag);
            count++;
        end
        if (count > 0) begin
            found[count - 1].last = 1'b1;
        end
        for (int i = 0; i < count; i++) begin
            expected_pixels.push_back(found[i]);
        end

        center_angle      = row_above_ang[c];
        row_above_ang[c]  = ang;
        row_above2_mag[c] = row_above_mag[c];
        row_above_mag[c]  = mag;

        if (last_col) begin
            next_col = 0;
            next_row = last_row ? 0 : (r + 1) & 1023;
        end else begin
            next_col = (c + 1) & 1023;
        end
    endfunction

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Channel helpers.
    // ------------------------------------------------------------------

    // Offers one pixel item, with random idle cycles in front of it when
    // gaps are enabled. Valid stays high after acceptance so that back to
    // back items need no extra edge.
    task automatic send_pixel(input mag_t mag, input angle_t ang);
        while (pixel_gaps && $urandom_range(99) < STALL_PERCENT) begin
            pixel_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pixel_ch.valid     <= 1'b1;
        pixel_ch.magnitude <= mag;
        pixel_ch.angle     <= ang;
        @(posedge clk);
        while (!pixel_ch.ready) begin
            @(posedge clk);
        end
        model_pixel(mag, ang);
        pixels_sent++;
    endtask

    // Stops the pixel stream and waits until the block has delivered every
    // expected result and had time to finish a pixel with no result.
    task automatic drain_results();
        pixel_ch.valid <= 1'b0;
        while (expected_pixels.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Registers only change while the block is idle.
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index, input int data);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data[DIM_BITS-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        if (index == CFG_IMAGE_WIDTH) begin
            width_setting = data[DIM_BITS-1:0];
        end else begin
            height_setting = data[DIM_BITS-1:0];
        end
    endtask

    task automatic set_geometry(input int width, input int height);
        write_reg(CFG_IMAGE_WIDTH, width);
        write_reg(CFG_IMAGE_HEIGHT, height);
    endtask

    // Sends pixels until the frame wraps back to the first pixel or until
    // max_count pixels went out (0 means no count limit). With reshape set,
    // the geometry is occasionally rewritten in the middle of the frame.
    task automatic stream_pixels(input fill_style_t style, input int max_count,
                                 input bit reshape);
        mag_t   mag;
        angle_t ang;
        int     count;
        count     = 0;
        ridge_col = $urandom_range(effective_dim(width_setting, WIDTH_CAP) - 1);
        ridge_row = $urandom_range(effective_dim(height_setting, DIM_CAP) - 1);
        do begin
            case (style)
                FILL_NOISE: begin
                    mag = mag_t'($urandom_range(MAG_MAX));
                    ang = angle_t'($urandom_range(1023));
                end
                FILL_TIES: begin
                    mag = mag_t'($urandom_range(3));
                    ang = angle_t'($urandom_range(720) - 360);
                end
                default: begin
                    // A bright column with a horizontal gradient and a bright
                    // row with a vertical one, so that ridges survive.
                    if (next_col == ridge_col) begin
                        mag = mag_t'($urandom_range(MAG_MAX, 160));
                        ang = angle_t'($urandom_range(88) - 44);
                    end else if (next_row == ridge_row) begin
                        mag = mag_t'($urandom_range(MAG_MAX, 160));
                        ang = angle_t'($urandom_range(225, 136));
                        if ($urandom_range(1) == 1) begin
                            ang = -ang;
                        end
                    end else begin
                        mag = mag_t'($urandom_range(120));
                        ang = angle_t'($urandom_range(720) - 360);
                    end
                end
            endcase
            send_pixel(mag, ang);
            count++;
            if (reshape && $urandom_range(99) < 4) begin
                write_reg($urandom_range(1) ? CFG_IMAGE_WIDTH : CFG_IMAGE_HEIGHT,
                          $urandom_range(12));
            end else if ($urandom_range(199) == 0) begin
                drain_results();
            end
        end while ((next_row != 0 || next_col != 0) && count != max_count);
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Reset geometry is 640 x 480. Twenty-four pixels of row 0 produce
    // nothing, which shows the row is longer than that. The width then
    // drops to 12 while the column counter sits at 24, so that pixel is the
    // last of its row at once. Rows 1 and 2 bring no bottom row results,
    // which shows the frame is taller than three rows. The height then
    // drops to 3 with the row counter at 3, so row 3 is the last one. This
    // also writes the line buffer columns below 12 several times, so later
    // geometry changes never expose unwritten entries.
    task automatic test_reset_geometry();
        stream_pixels(FILL_NOISE, 24, 1'b0);
        write_reg(CFG_IMAGE_WIDTH, 12);
        stream_pixels(FILL_NOISE, 25, 1'b0);
        write_reg(CFG_IMAGE_HEIGHT, 3);
        stream_pixels(FILL_NOISE, 0, 1'b0);
    endtask

    // Three 3x3 frames with register values below the legal range. The
    // single interior pixel is a clear ridge in the first frame, a zero
    // magnitude in the second and a tie in the third. Magnitudes and angles
    // also take their extreme values, angles beyond half a turn included.
    task automatic test_clamped_minimum();
        mag_t mags[27] = '{
            255,   0, 255,    0, 255,   0,  255,   0, 255,
              1,   2,   3,    4,   0,   5,    6,   7,   8,
            128, 128, 128,  128, 128, 128,  128, 128, 128};
        angle_t angs[27] = '{
             511, -512,  360, -360, -512,    0,   45,  -45,  511,
               0,    1,   -1,    2,  100,   -2,    3,   -3,    4,
            -100, -200, -300,  300,  180,  200, -400,  400,   -1};
        for (int f = 0; f < 3; f++) begin
            set_geometry(f, 2 - f);
            for (int i = 0; i < 9; i++) begin
                send_pixel(mags[f * 9 + i], angs[f * 9 + i]);
            end
        end
    endtask

    // Interior pixels of 5x4 frames take the angles on and next to every
    // sector edge, in both signs, plus zero and the field extremes.
    task automatic test_sector_bounds();
        angle_t edges[24] = '{
            -512, -316, -315, -314, -226, -225, -224, -136, -135, -134, -46, -45,
             -44,    0,   45,   46,  135,  136,  225,  226,  315,  316, 360, 511};
        int     k;
        mag_t   mag;
        angle_t ang;
        k = 0;
        set_geometry(5, 4);
        for (int f = 0; f < 4; f++) begin
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 5; c++) begin
                    if (r >= 1 && r <= 2 && c >= 1 && c <= 3) begin
                        mag = mag_t'($urandom_range(MAG_MAX, 128));
                        ang = edges[k];
                        k++;
                    end else begin
                        mag = mag_t'($urandom_range(MAG_MAX));
                        ang = angle_t'($urandom_range(1023));
                    end
                    send_pixel(mag, ang);
                end
            end
        end
    endtask

    // The largest width register value with the smallest height, then the
    // smallest width with the largest height. A partial row or a partial
    // column of rows shows the clamped size is large, and a size change in
    // the middle of the frame then closes it.
    task automatic test_maximum_geometry();
        set_geometry((1 << DIM_BITS) - 1, 0);
        stream_pixels(FILL_RIDGE, 40, 1'b0);
        write_reg(CFG_IMAGE_WIDTH, 3);
        stream_pixels(FILL_NOISE, 0, 1'b0);
        set_geometry(1, (1 << DIM_BITS) - 1);
        stream_pixels(FILL_NOISE, 30, 1'b0);
        write_reg(CFG_IMAGE_HEIGHT, 0);
        stream_pixels(FILL_NOISE, 0, 1'b0);
    endtask

    // Random small frames, mostly complete, some with the geometry changed
    // half way. Frames that start within a window of the item count run
    // with no idling on either side.
    task automatic test_random_frames();
        int  start;
        int  width;
        bit  quiet;
        start = pixels_sent;
        while (pixels_sent - start < RANDOM_PIXELS) begin
            quiet         = (pixels_sent - start) >= 40 && (pixels_sent - start) < 110;
            pixel_gaps    = !quiet;
            result_stalls = !quiet;
            if ($urandom_range(9) == 0) begin
                width = $urandom_range(2);
            end else begin
                width = $urandom_range(12, 3);
            end
            set_geometry(width, $urandom_range(8));
            stream_pixels(fill_style_t'($urandom_range(2)), 0, $urandom_range(3) == 0);
        end
        pixel_gaps    = 1'b1;
        result_stalls = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Result checker and sink side. Each accepted result item is compared
    // with the oldest expectation; ready is redrawn on every edge.
    // ------------------------------------------------------------------
    initial begin
        pixel_result_t got;
        pixel_result_t want;
        result_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready) begin
                got = '{result_ch.out_row, result_ch.out_col, result_ch.value,
                        result_ch.last_of_run};
                if (expected_pixels.size() == 0) begin
                    $error("result item for (%0d,%0d) arrived with nothing expected",
                           got.row, got.col);
                    mismatches++;
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("out_row", 32'(want.row), 32'(got.row));
                    check_field("out_col", 32'(want.col), 32'(got.col));
                    check_field("value", 32'(want.value), 32'(got.value));
                    check_field("last_of_run", 32'(want.last), 32'(got.last));
                end
            end
            result_ch.ready <= !result_stalls || $urandom_range(99) >= STALL_PERCENT;
        end
    end

    // The run ends if no item moves on either channel for too long.
    always @(posedge clk) begin
        if ((pixel_ch.valid && pixel_ch.ready) || (result_ch.valid && result_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial begin
        pixel_ch.valid     = 1'b0;
        pixel_ch.magnitude = '0;
        pixel_ch.angle     = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_geometry();
        test_clamped_minimum();
        test_sector_bounds();
        test_maximum_geometry();
        test_random_frames();

        // Every expectation has to come back before the verdict.
        drain_results();
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
